>>> sv/double_ended_queue_unit_assert.svh
// Assertion macros for the double-ended queue unit.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define DEQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/deq_pkg.sv
// Package: sizes, codes and controller/datapath bundles of the deque unit.
`default_nettype none
package deq_pkg;

  localparam int DEPTH   = 16;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = 5;
  localparam int DATA_W  = 32;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PEEK_REAR  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    RV_ZERO = 2'd0,
    RV_ONES = 2'd1,
    RV_MEM  = 2'd2
  } rv_sel_t;

  typedef struct packed {
    logic              load;
    logic              push_front;
    logic              push_rear;
    logic              pop_front;
    logic              pop_rear;
    logic              rd_en;
    logic              rd_rear;
    rv_sel_t           rv_sel;
    logic [STAT_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sts_t;

endpackage
`default_nettype wire

>>> sv/deq_if.sv
// Valid/ready channel interfaces for the deque unit input and result.
`default_nettype none
interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::ACT_W-1:0]           action;
  logic signed [deq_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, action, push_value, input ready);
  modport sink   (input valid, action, push_value, output ready);
endinterface

interface deq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::DATA_W-1:0]   read_value;
  logic [deq_pkg::STAT_W-1:0]          status;
  logic [deq_pkg::CNT_W-1:0]           entry_count;

  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface
`default_nettype wire

>>> sv/deq_ctrl.sv
// Deque controller: handshake state machine and action decode.
`default_nettype none
module deq_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [deq_pkg::ACT_W-1:0]   action,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  input  wire deq_pkg::sts_t               sts,
  output deq_pkg::cmd_t                    cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign out_valid = (state_r == S_RESP);
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (accept) state_nxt = S_RESP;
        else if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.rv_sel = deq_pkg::RV_ZERO;
    cmd.status = deq_pkg::ST_OK;
    if (accept) begin
      if (action inside {deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR}) begin
        if (sts.full) begin
          cmd.status = deq_pkg::ST_FULL;
        end else begin
          cmd.push_front = (action == deq_pkg::ACT_PUSH_FRONT);
          cmd.push_rear  = (action == deq_pkg::ACT_PUSH_REAR);
        end
      end else if (action inside {[deq_pkg::ACT_POP_FRONT:deq_pkg::ACT_PEEK_REAR]}) begin
        if (sts.empty) begin
          cmd.status = deq_pkg::ST_EMPTY;
          cmd.rv_sel = deq_pkg::RV_ONES;
        end else begin
          cmd.rv_sel = deq_pkg::RV_MEM;
          cmd.rd_en  = 1'b1;
          case (action)
            deq_pkg::ACT_POP_FRONT:  cmd.pop_front = 1'b1;
            deq_pkg::ACT_POP_REAR: begin
              cmd.pop_rear = 1'b1;
              cmd.rd_rear  = 1'b1;
            end
            deq_pkg::ACT_PEEK_REAR:  cmd.rd_rear = 1'b1;
            default:                 cmd.rd_rear = 1'b0;
          endcase
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/deq_dp.sv
// Deque datapath: ring store, head/tail pointers, occupancy and result registers.
`default_nettype none
module deq_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire deq_pkg::cmd_t                      cmd,
  input  wire logic signed [deq_pkg::DATA_W-1:0]  push_value,
  output deq_pkg::sts_t                           sts,
  output logic signed [deq_pkg::DATA_W-1:0]       read_value,
  output logic [deq_pkg::STAT_W-1:0]              status,
  output logic [deq_pkg::CNT_W-1:0]               entry_count
);

  localparam logic [deq_pkg::ADDR_W-1:0] LAST = deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1);

  logic [deq_pkg::DATA_W-1:0] mem [deq_pkg::DEPTH];

  logic [deq_pkg::ADDR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [deq_pkg::ADDR_W-1:0] head_prev, head_next, tail_prev;
  logic [deq_pkg::ADDR_W-1:0] waddr, raddr;
  logic [deq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [deq_pkg::DATA_W-1:0] rdata_r;
  logic [deq_pkg::STAT_W-1:0] status_r;
  deq_pkg::rv_sel_t           rv_sel_r;

  assign head_prev = (head_r == '0)   ? LAST : head_r - 1'b1;
  assign head_next = (head_r == LAST) ? '0   : head_r + 1'b1;
  assign tail_prev = (tail_r == '0)   ? LAST : tail_r - 1'b1;

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));

  assign waddr = cmd.push_front ? head_prev : tail_r;
  assign raddr = cmd.rd_rear    ? tail_prev : head_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.push_front) head_nxt = head_prev;
    if (cmd.pop_front)  head_nxt = head_next;
    if (cmd.push_rear)  tail_nxt = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    if (cmd.pop_rear)   tail_nxt = tail_prev;
    if (cmd.push_front || cmd.push_rear) count_nxt = count_r + 1'b1;
    if (cmd.pop_front || cmd.pop_rear)   count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_front || cmd.push_rear) mem[waddr] <= push_value;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= cmd.status;
      rv_sel_r <= cmd.rv_sel;
    end
  end

  always_comb begin
    case (rv_sel_r)
      deq_pkg::RV_ONES: read_value = '1;
      deq_pkg::RV_MEM:  read_value = rdata_r;
      default:          read_value = '0;
    endcase
  end

  assign status      = status_r;
  assign entry_count = count_r;

endmodule
`default_nettype wire

>>> sv/double_ended_queue_unit.sv
// A result is registered and appears in the cycle after its input transfer.
// Throughput: one item per cycle while results are taken; one result register
// parts the channels, so a new transfer is taken when the held result leaves.
// The ring store is a 16-entry register array with one write and one
// registered read port. Synchronous active-low reset empties the queue; store
// contents are not cleared.
`default_nettype none
`include "double_ended_queue_unit_assert.svh"
module double_ended_queue_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  deq_in_if.sink     in_chan,
  deq_out_if.source  out_chan
);

  deq_pkg::cmd_t cmd;
  deq_pkg::sts_t sts;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .action    (in_chan.action),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  deq_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .push_value  (in_chan.push_value),
    .sts         (sts),
    .read_value  (out_chan.read_value),
    .status      (out_chan.status),
    .entry_count (out_chan.entry_count)
  );

  `DEQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, out_chan.entry_count <= deq_pkg::CNT_W'(deq_pkg::DEPTH), "occupancy above depth")
  `DEQ_ASSERT_NOW(a_full_count, clk, rst_n, out_chan.valid && out_chan.status == deq_pkg::ST_FULL, out_chan.entry_count == deq_pkg::CNT_W'(deq_pkg::DEPTH), "full status with free space")
  `DEQ_ASSERT_NOW(a_empty_result, clk, rst_n, out_chan.valid && out_chan.status == deq_pkg::ST_EMPTY, out_chan.entry_count == '0 && out_chan.read_value == -1, "bad empty result")
  `DEQ_ASSERT_NEXT(a_transfer_result, clk, rst_n, in_chan.valid && in_chan.ready, out_chan.valid, "no result after input transfer")

endmodule
`default_nettype wire

>>> tb/tb.sv
// Testbench for double_ended_queue_unit: directed table, random bursts, deque predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [deq_pkg::ACT_W-1:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [deq_pkg::ACT_W-1:0] ACT_UNUSED_7 = 3'd7;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_IDLE     = 17;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} burst_mix_t;

  typedef struct packed {
    logic signed [deq_pkg::DATA_W-1:0] read_value;
    logic [deq_pkg::STAT_W-1:0]        status;
    logic [deq_pkg::CNT_W-1:0]         entry_count;
  } deq_result_t;

  typedef struct packed {
    logic [deq_pkg::ACT_W-1:0]         action;
    logic signed [deq_pkg::DATA_W-1:0] push_value;
    int                                reps;
    bit                                typed;
    deq_result_t                       result;
  } stim_row_t;

  localparam deq_result_t NO_RESULT = '{32'sd0, deq_pkg::ST_OK, 5'd0};
  localparam deq_result_t EMPTY_RESULT = '{-32'sd1, deq_pkg::ST_EMPTY, 5'd0};
  localparam deq_result_t FULL_RESULT = '{32'sd0, deq_pkg::ST_FULL, 5'd16};

  localparam stim_row_t DIRECTED_ROWS [0:17] = '{
    '{deq_pkg::ACT_POP_FRONT,  32'sd0,         1, 1'b1, EMPTY_RESULT},
    '{deq_pkg::ACT_POP_REAR,   32'sd0,         1, 1'b1, EMPTY_RESULT},
    '{deq_pkg::ACT_PEEK_FRONT, 32'sh5A5A_5A5A, 1, 1'b1, EMPTY_RESULT},
    '{deq_pkg::ACT_PEEK_REAR,  -32'sd1,        1, 1'b1, EMPTY_RESULT},
    '{ACT_UNUSED_6,            32'sh7FFF_FFFF, 1, 1'b1, NO_RESULT},
    '{ACT_UNUSED_7,            -32'sd1,        1, 1'b1, NO_RESULT},
    '{deq_pkg::ACT_PUSH_FRONT, 32'sh7FFF_FFFF, 1, 1'b1, '{32'sd0, deq_pkg::ST_OK, 5'd1}},
    '{deq_pkg::ACT_PUSH_REAR,  32'sh8000_0000, 1, 1'b1, '{32'sd0, deq_pkg::ST_OK, 5'd2}},
    '{deq_pkg::ACT_PUSH_FRONT, 32'sd0,         7, 1'b0, NO_RESULT},
    '{deq_pkg::ACT_PUSH_REAR,  32'sh1234_5678, 7, 1'b0, NO_RESULT},
    '{deq_pkg::ACT_PUSH_FRONT, -32'sd1,        1, 1'b1, FULL_RESULT},
    '{deq_pkg::ACT_PUSH_REAR,  32'sh8000_0000, 1, 1'b1, FULL_RESULT},
    '{deq_pkg::ACT_PEEK_FRONT, 32'sd0,         1, 1'b0, NO_RESULT},
    '{deq_pkg::ACT_PEEK_REAR,  32'sd0,         1, 1'b0, NO_RESULT},
    '{deq_pkg::ACT_POP_FRONT,  32'sd0,         1, 1'b0, NO_RESULT},
    '{deq_pkg::ACT_POP_REAR,   32'sd0,         1, 1'b0, NO_RESULT},
    '{ACT_UNUSED_6,            32'sd0,         1, 1'b0, NO_RESULT},
    '{deq_pkg::ACT_PEEK_REAR,  32'sd0,         1, 1'b0, NO_RESULT}
  };

  logic clk;
  logic rst_n;

  deq_in_if  in_chan();
  deq_out_if out_chan();

  double_ended_queue_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // predictor state
  logic signed [deq_pkg::DATA_W-1:0] ring_store [deq_pkg::DEPTH];
  int ring_head = 0;
  int ring_tail = 0;
  int ring_count = 0;

  deq_result_t expected_results [$];
  bit          item_typed;
  deq_result_t item_result;
  bit          idle_off;
  int          fail_count = 0;
  int          cycle_count = 0;

  function automatic int idle_cycles();
    return idle_off ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic logic signed [deq_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'sd0;
      1: return -32'sd1;
      2: return 32'sh7FFF_FFFF;
      3: return 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic deq_result_t deque_apply(logic [deq_pkg::ACT_W-1:0] act,
                                              logic signed [deq_pkg::DATA_W-1:0] val);
    deq_result_t r;
    int rear;
    r = NO_RESULT;
    rear = (ring_tail == 0) ? deq_pkg::DEPTH - 1 : ring_tail - 1;
    case (act)
      deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR: begin
        if (ring_count >= deq_pkg::DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else if (act == deq_pkg::ACT_PUSH_FRONT) begin
          ring_head = (ring_head == 0) ? deq_pkg::DEPTH - 1 : ring_head - 1;
          ring_store[ring_head] = val;
          ring_count++;
        end else begin
          ring_store[ring_tail] = val;
          ring_tail = (ring_tail == deq_pkg::DEPTH - 1) ? 0 : ring_tail + 1;
          ring_count++;
        end
      end
      deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_REAR,
      deq_pkg::ACT_PEEK_FRONT, deq_pkg::ACT_PEEK_REAR: begin
        if (ring_count == 0) begin
          r.read_value = -32'sd1;
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          if (act == deq_pkg::ACT_POP_FRONT || act == deq_pkg::ACT_PEEK_FRONT) begin
            r.read_value = ring_store[ring_head];
          end else begin
            r.read_value = ring_store[rear];
          end
          if (act == deq_pkg::ACT_POP_FRONT) begin
            ring_head = (ring_head == deq_pkg::DEPTH - 1) ? 0 : ring_head + 1;
            ring_count--;
          end else if (act == deq_pkg::ACT_POP_REAR) begin
            ring_tail = rear;
            ring_count--;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = deq_pkg::CNT_W'(ring_count);
    return r;
  endfunction

  task automatic send_item(input logic [deq_pkg::ACT_W-1:0] act,
                           input logic signed [deq_pkg::DATA_W-1:0] val,
                           input bit typed, input deq_result_t res);
    int gap;
    gap = idle_cycles();
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.action <= act;
    in_chan.push_value <= val;
    item_typed <= typed;
    item_result <= res;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
  endtask

  // scoreboard: results first, then the transfer of this edge
  always @(posedge clk) begin
    deq_result_t got;
    deq_result_t want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.read_value, out_chan.status, out_chan.entry_count};
        if (expected_results.size() == 0) begin
          $error("unexpected result: read_value %0d status %0d entry_count %0d",
                 got.read_value, got.status, got.entry_count);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            fail_count++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        want = deque_apply(in_chan.action, in_chan.push_value);
        expected_results.push_back(item_typed ? item_result : want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("double_ended_queue_unit test failed");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_cycles();
      @(negedge clk);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
    end
  end

  initial begin
    int counted;
    int burst_len;
    int push_pct;
    burst_mix_t mix;
    logic [deq_pkg::ACT_W-1:0] act;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.action = deq_pkg::ACT_PUSH_FRONT;
    in_chan.push_value = 32'sd0;
    item_typed = 1'b0;
    item_result = NO_RESULT;
    idle_off = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i]) begin
      for (int k = 0; k < DIRECTED_ROWS[i].reps; k++) begin
        send_item(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].push_value + k,
                  DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
      end
    end

    // bursts that lean toward filling, draining or neither
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      mix = burst_mix_t'($urandom_range(MIX_BALANCED, MIX_DRAIN));
      idle_off = ($urandom_range(0, 3) == 0);
      burst_len = $urandom_range(10, 60);
      push_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 50;
      repeat (burst_len) begin
        if ($urandom_range(0, 99) < 3) begin
          act = deq_pkg::ACT_W'($urandom_range(ACT_UNUSED_6, ACT_UNUSED_7));
        end else begin
          if ($urandom_range(0, 99) < push_pct) begin
            act = deq_pkg::ACT_W'($urandom_range(deq_pkg::ACT_PUSH_FRONT,
                                                 deq_pkg::ACT_PUSH_REAR));
          end else begin
            act = deq_pkg::ACT_W'($urandom_range(deq_pkg::ACT_POP_FRONT,
                                                 deq_pkg::ACT_PEEK_REAR));
          end
          counted++;
        end
        send_item(act, random_value(), 1'b0, NO_RESULT);
      end
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    idle_off = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("double_ended_queue_unit test passed");
    end else begin
      $display("double_ended_queue_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/deq_pkg.sv
sv/deq_if.sv
sv/deq_ctrl.sv
sv/deq_dp.sv
sv/double_ended_queue_unit.sv
tb/tb.sv
